// File: src/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds the operation and result transaction structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;

    // operation codes
    localparam logic [1:0] MODE_PUSH_BACK  = 2'd0;
    localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
    localparam logic [1:0] MODE_POP_BACK   = 2'd2;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
    } res_t;

endpackage

`default_nettype wire

// File: src/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
// Double-ended queue of signed 32-bit values kept in a ring buffer RAM.
// Depends on dq_pkg (transaction types, codes) and dq_ram (slot storage).
//
// Usage:
//   op channel (op_valid / op_stall / op_data) carries one operation per
//   transaction: push back, push front, pop back or pop front.
//   res channel (res_valid / res_stall / res_data) returns one result per
//   operation: status, element count, empty flag, front and back values.
//   Front and back values are cached in registers; the slot RAM is only
//   read when a pop exposes a new end element.
// Result timing:
//   Pushes, rejected operations and pops that empty the queue: result is
//   registered on acceptance, one operation per cycle while res_stall does
//   not hold it. Pops that leave elements behind: the new end slot is read
//   from RAM, then the result is registered; op_stall is high meanwhile.
// Stalls: the result register holds while res_stall is high; op_stall rises
//   when that register is occupied and not being drained.
// Reset: queue empty, front index zero, no result pending. Slot contents are
//   not cleared; only slots that were pushed are ever read.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         op_valid,
    output logic              op_stall,
    input  wire dq_pkg::op_t  op_data,
    output logic              res_valid,
    input  wire logic         res_stall,
    output dq_pkg::res_t      res_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int VW = dq_pkg::VALUE_W;
    localparam int OUT_CNT_W = dq_pkg::COUNT_W;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic          state_reg,     state_next;
    logic          pop_back_reg,  pop_back_next;
    logic [AW-1:0] front_reg,     front_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [VW-1:0] front_val_reg, front_val_next;
    logic [VW-1:0] back_val_reg,  back_val_next;
    logic          res_valid_reg, res_valid_next;
    dq_pkg::res_t  res_reg,       res_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [VW-1:0] rd_data;

    logic          out_free;
    logic          accept;
    logic          full;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;

    function automatic logic [AW-1:0] wrap_pos(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[AW-1:0];
    endfunction

    function automatic dq_pkg::res_t make_res(input logic [1:0] status,
                                              input logic [CW-1:0] cnt,
                                              input logic [VW-1:0] fv,
                                              input logic [VW-1:0] bv);
        dq_pkg::res_t r;
        r.status      = status;
        r.count       = OUT_CNT_W'(cnt);
        r.is_empty    = (cnt == '0);
        r.front_value = (cnt == '0) ? '0 : fv;
        r.back_value  = (cnt == '0) ? '0 : bv;
        return r;
    endfunction

    dq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op_data.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign op_stall  = (state_reg == ST_READ) || !out_free;
    assign accept    = op_valid && !op_stall;
    assign full      = (count_reg == CW'(DEPTH));
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        pop_back_next  = pop_back_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = wrap_pos(SW'(front_reg) + SW'(count_reg));
        rd_en          = 1'b0;
        rd_addr        = front_inc;

        if (state_reg == ST_READ)
        begin
            // new end element arrives from the RAM; result slot is known free
            if (pop_back_reg)
            begin
                back_val_next = rd_data;
            end
            else
            begin
                front_val_next = rd_data;
            end
            res_next       = make_res(dq_pkg::STATUS_OK, count_reg,
                                      front_val_next, back_val_next);
            res_valid_next = 1'b1;
            state_next     = ST_RUN;
        end
        else
        begin
            if (res_valid_reg && !res_stall)
            begin
                res_valid_next = 1'b0;
            end
            if (accept)
            begin
                unique case (op_data.mode)
                    dq_pkg::MODE_PUSH_BACK,
                    dq_pkg::MODE_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            res_next = make_res(dq_pkg::STATUS_OVERFLOW, count_reg,
                                                front_val_reg, back_val_reg);
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (op_data.mode == dq_pkg::MODE_PUSH_FRONT)
                            begin
                                wr_addr        = front_dec;
                                front_next     = front_dec;
                                front_val_next = op_data.value;
                                if (count_reg == '0)
                                begin
                                    back_val_next = op_data.value;
                                end
                            end
                            else
                            begin
                                back_val_next = op_data.value;
                                if (count_reg == '0)
                                begin
                                    front_val_next = op_data.value;
                                end
                            end
                            res_next = make_res(dq_pkg::STATUS_OK, count_next,
                                                front_val_next, back_val_next);
                        end
                        res_valid_next = 1'b1;
                    end
                    dq_pkg::MODE_POP_BACK,
                    dq_pkg::MODE_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next = make_res(dq_pkg::STATUS_UNDERFLOW, count_reg,
                                                front_val_reg, back_val_reg);
                            res_valid_next = 1'b1;
                        end
                        else
                        begin
                            count_next    = count_reg - CW'(1);
                            pop_back_next = (op_data.mode == dq_pkg::MODE_POP_BACK);
                            if (op_data.mode == dq_pkg::MODE_POP_FRONT)
                            begin
                                front_next = front_inc;
                            end
                            if (count_reg == CW'(1))
                            begin
                                res_next = make_res(dq_pkg::STATUS_OK, count_next,
                                                    front_val_reg, back_val_reg);
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                // fetch the element that becomes the new end
                                rd_en = 1'b1;
                                if (op_data.mode == dq_pkg::MODE_POP_BACK)
                                begin
                                    rd_addr = wrap_pos(SW'(front_reg) + SW'(count_reg)
                                                       - SW'(2));
                                end
                                res_valid_next = 1'b0;
                                state_next     = ST_READ;
                            end
                        end
                    end
                    default:
                    begin
                        res_valid_next = res_valid_next;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            pop_back_reg  <= 1'b0;
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pop_back_reg  <= pop_back_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        res_reg       <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(front_reg) < SW'(DEPTH))
        else $error("front index out of range");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !res_valid_reg)
        else $error("RAM read pending while result register occupied");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !op_data.mode[1] && !full) |=>
            (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted push did not grow the queue");

    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (res_valid_reg && state_reg == ST_RUN))
        else $error("pop read did not produce a result");

endmodule

`default_nettype wire

// File: tb/double_ended_queue_tb.sv
// Self-checking testbench for double_ended_queue: random and directed deque operations.
// Depends on dq_pkg (op_t, res_t, mode and status codes) and the double_ended_queue RTL.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int DEPTH          = 256;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {STIM_OP, STIM_DRAIN, STIM_HOLD} stim_kind_t;

    typedef struct {
        stim_kind_t   kind;
        dq_pkg::op_t  op;
        int           gap;
    } stim_t;

    logic         clk;
    logic         rst_n;
    logic         op_valid;
    logic         op_stall;
    dq_pkg::op_t  op_data;
    logic         res_valid;
    logic         res_stall;
    dq_pkg::res_t res_data;

    double_ended_queue #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    // Deque state mirrored by the predictor
    logic signed [dq_pkg::VALUE_W-1:0] ring [DEPTH];
    int unsigned head;
    int unsigned held;

    stim_t        stim_q[$];
    dq_pkg::res_t expected_views[$];

    int   ops_queued;
    int   ops_accepted;
    int   results_seen;
    int   error_count;
    int   idle_cycles;
    int   n_overflow;
    int   n_underflow;
    int   peak_fill;
    logic op_taken;
    logic res_taken;
    logic hold_toggle;
    logic hold_seen;
    int   gap_left;
    int   hold_left;
    int   stall_left;
    bit   rx_busy;
    bit   tx_busy;
    int   burst_left;

    function automatic dq_pkg::res_t deque_apply(dq_pkg::op_t op);
        dq_pkg::res_t r;
        r.status = dq_pkg::STATUS_OK;
        case (op.mode)
            dq_pkg::MODE_PUSH_BACK, dq_pkg::MODE_PUSH_FRONT:
                if (held == DEPTH) begin
                    r.status = dq_pkg::STATUS_OVERFLOW;
                end
                else if (op.mode == dq_pkg::MODE_PUSH_BACK) begin
                    ring[(head + held) % DEPTH] = op.value;
                    held++;
                end
                else begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = op.value;
                    held++;
                end
            dq_pkg::MODE_POP_BACK, dq_pkg::MODE_POP_FRONT:
                if (held == 0) begin
                    r.status = dq_pkg::STATUS_UNDERFLOW;
                end
                else if (op.mode == dq_pkg::MODE_POP_BACK) begin
                    held--;
                end
                else begin
                    head = (head + 1) % DEPTH;
                    held--;
                end
        endcase
        r.count       = dq_pkg::COUNT_W'(held);
        r.is_empty    = (held == 0);
        r.front_value = (held == 0) ? '0 : ring[head];
        r.back_value  = (held == 0) ? '0 : ring[(head + held - 1) % DEPTH];
        return r;
    endfunction

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic add_op(logic [1:0] mode, logic signed [dq_pkg::VALUE_W-1:0] value, int gap);
        stim_t s;
        s.kind     = STIM_OP;
        s.op.mode  = mode;
        s.op.value = value;
        s.gap      = gap;
        stim_q.insert(stim_q.size(), s);
        ops_queued++;
    endtask

    task automatic add_marker(stim_kind_t kind);
        stim_t s;
        s.kind = kind;
        s.op   = '0;
        s.gap  = 0;
        stim_q.insert(stim_q.size(), s);
    endtask

    // push_pct biases the phase toward filling or emptying the queue
    task automatic random_phase(int len, int push_pct, bit with_hold);
        logic [1:0]                        mode;
        logic signed [dq_pkg::VALUE_W-1:0] value;
        int                                gap;
        for (int i = 0; i < len; i++) begin
            if (with_hold && i == 10) begin
                add_marker(STIM_HOLD);
                burst_left = 40;
            end
            if ($urandom_range(0, 99) < push_pct)
                mode = $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_FRONT : dq_pkg::MODE_PUSH_BACK;
            else
                mode = $urandom_range(0, 1) ? dq_pkg::MODE_POP_FRONT : dq_pkg::MODE_POP_BACK;
            case ($urandom_range(0, 7))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 31) == 0)
                tx_busy = !tx_busy;
            if (burst_left != 0) begin
                gap = 0;
                burst_left--;
            end
            else begin
                gap = tx_busy ? $urandom_range(0, 19) : 0;
            end
            add_op(mode, value, gap);
        end
    endtask

    // Driver: presents the next operation at the falling edge
    always @(negedge clk) begin
        logic nxt_valid;
        nxt_valid = op_valid && !op_taken;
        if (rst_n && !nxt_valid) begin
            while (stim_q.size() != 0 && stim_q[0].kind != STIM_OP
                   && !(stim_q[0].kind == STIM_DRAIN && expected_views.size() != 0)) begin
                if (stim_q[0].kind == STIM_HOLD)
                    hold_toggle <= !hold_toggle;
                stim_q.delete(0);
            end
            if (stim_q.size() != 0 && stim_q[0].kind == STIM_OP) begin
                if (gap_left < 0)
                    gap_left = stim_q[0].gap;
                if (gap_left == 0) begin
                    op_data   <= stim_q[0].op;
                    nxt_valid = 1'b1;
                    gap_left  = -1;
                    stim_q.delete(0);
                end
                else begin
                    gap_left--;
                end
            end
        end
        op_valid <= nxt_valid;
    end

    // Result side back-pressure: per-result random stall plus the long hold-off
    always @(negedge clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (rst_n) begin
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (res_taken) begin
                if ($urandom_range(0, 47) == 0)
                    rx_busy = !rx_busy;
                stall_left = rx_busy ? $urandom_range(0, 19) : 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (stall_left != 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end
        end
        res_stall <= nxt_stall;
    end

    // Monitor: checks results, predicts accepted operations, runs the watchdog
    always @(posedge clk) begin
        dq_pkg::res_t want;
        logic         op_fire;
        logic         res_fire;
        op_fire  = rst_n && op_valid && !op_stall;
        res_fire = rst_n && res_valid && !res_stall;
        if (res_fire) begin
            results_seen++;
            if (expected_views.size() == 0) begin
                $error("result transaction with no operation pending: %p", res_data);
                error_count++;
            end
            else begin
                want = expected_views[0];
                expected_views.delete(0);
                check_field("status", want.status, res_data.status);
                check_field("count", want.count, res_data.count);
                check_field("is_empty", want.is_empty, res_data.is_empty);
                check_field("front_value", want.front_value, res_data.front_value);
                check_field("back_value", want.back_value, res_data.back_value);
                if (want.status == dq_pkg::STATUS_OVERFLOW)
                    n_overflow++;
                if (want.status == dq_pkg::STATUS_UNDERFLOW)
                    n_underflow++;
                if (int'(want.count) > peak_fill)
                    peak_fill = int'(want.count);
            end
        end
        if (op_fire) begin
            expected_views.insert(expected_views.size(), deque_apply(op_data));
            ops_accepted++;
        end
        op_taken  <= op_fire;
        res_taken <= res_fire;
        if (op_fire || res_fire)
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("double_ended_queue regression: fail");
            $finish;
        end
    end

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        op_valid    = 1'b0;
        op_data     = '0;
        res_stall   = 1'b0;
        op_taken    = 1'b0;
        res_taken   = 1'b0;
        hold_toggle = 1'b0;
        hold_seen   = 1'b0;
        gap_left    = -1;
        hold_left   = 0;
        stall_left  = 0;
        rx_busy     = 1'b0;
        tx_busy     = 1'b0;
        burst_left  = 0;
        head        = 0;
        held        = 0;

        // empty-queue pops, value extremes at both ends, emptying from each side
        add_op(dq_pkg::MODE_POP_BACK, 32'h1234_5678, 0);
        add_op(dq_pkg::MODE_POP_FRONT, -1, 0);
        add_op(dq_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF, 0);
        add_op(dq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 0);
        add_op(dq_pkg::MODE_PUSH_BACK, -1, 0);
        add_op(dq_pkg::MODE_PUSH_FRONT, 0, 0);
        add_op(dq_pkg::MODE_PUSH_BACK, 1, 0);
        add_op(dq_pkg::MODE_POP_FRONT, 0, 0);
        add_op(dq_pkg::MODE_POP_BACK, 0, 0);
        add_op(dq_pkg::MODE_POP_FRONT, 0, 0);
        add_op(dq_pkg::MODE_POP_BACK, 0, 0);
        add_op(dq_pkg::MODE_POP_FRONT, 0, 0);
        add_op(dq_pkg::MODE_POP_BACK, 0, 0);
        add_op(dq_pkg::MODE_PUSH_FRONT, 32'h5555_5555, 0);
        add_op(dq_pkg::MODE_POP_BACK, 32'hFFFF_FFFF, 0);
        add_op(dq_pkg::MODE_PUSH_BACK, 32'hAAAA_AAAA, 0);
        add_op(dq_pkg::MODE_POP_FRONT, 0, 0);
        add_op(dq_pkg::MODE_POP_FRONT, 0, 0);
        add_marker(STIM_DRAIN);

        // fill to overflow, empty to underflow, mixed traffic, then fill and empty again
        random_phase(400, 90, 1'b1);
        add_marker(STIM_DRAIN);
        random_phase(400, 10, 1'b0);
        random_phase(400, 50, 1'b0);
        add_marker(STIM_DRAIN);
        random_phase(400, 88, 1'b1);
        random_phase(400, 12, 1'b0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (ops_accepted == ops_queued);
        wait (expected_views.size() == 0);
        repeat (8) @(posedge clk);

        $display("%0d operations, %0d results checked", ops_accepted, results_seen);
        $display("%0d dropped pushes, %0d empty pops, peak fill %0d of %0d",
                 n_overflow, n_underflow, peak_fill, DEPTH);
        if (error_count == 0)
            $display("double_ended_queue regression: pass");
        else
            $display("double_ended_queue regression: fail");
        $finish;
    end

endmodule

// File: sim.f
src/dq_pkg.sv
src/dq_ram.sv
src/double_ended_queue.sv
tb/double_ended_queue_tb.sv
